>>> rtl/smvm_pkg.sv
// ---------------------------------------------------------------------------
// smvm_pkg
// Shared types and constants for the sample mean and variance block.
// ---------------------------------------------------------------------------
package smvm_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 256;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MDIV,
    ST_MFIX,
    ST_RD,
    ST_ACC,
    ST_ADIV,
    ST_VDIV,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage

>>> rtl/sample_mean_variance_moments.sv
// ---------------------------------------------------------------------------
// sample_mean_variance_moments
// Two-pass mean, mean absolute deviation, variance and standard deviation.
// ---------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | sample, is_last
// out     | output    | out_valid / out_ready  | mean_value, mean_abs_dev,
//         |           |                        | variance, std_dev, status
// A sample not marked last is stored and the input stays ready. A last sample
// runs one shared shift-subtract unit: mean division, deviation pass, divisions
// for deviation and variance, square root, hand-over; too few goes straight to
// the hand-over. The next set loads while a result waits; a new result stalls
// the input until the output register is free. Reset is synchronous, active high.
module sample_mean_variance_moments
  import smvm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] mean_value,
  output logic [23:0]        mean_abs_dev,
  output logic [39:0]        variance,
  output logic [23:0]        std_dev,
  output logic [1:0]         status
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic signed [15:0] mem [MAX_SAMPLES];
  logic signed [15:0] rd_data;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic signed [31:0] sum;
  logic ovf;
  logic [6:0] iter;

  // shared shift-subtract unit: quotient/root in q, remainder in r
  logic [63:0] q, num;
  logic [63:0] r;
  logic [32:0] den;
  logic neg;

  logic signed [31:0] mean;
  logic [39:0] abs_sum;
  logic [63:0] sq_sum;
  logic [32:0] ad;

  // finished statistics, waiting for the output register
  logic [23:0] mad_w;
  logic [39:0] var_w;
  logic [23:0] sd_w;
  status_t     stat_w;

  logic acc_in;
  logic out_load;
  logic room;
  logic [CW-1:0] n_in;
  logic signed [31:0] sum_in;
  logic [31:0] sum_mag;

  assign in_ready = (state == ST_LOAD);
  assign acc_in   = in_valid && in_ready;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // count and sum as they stand once the incoming sample is stored
  assign room    = count < CW'(MAX_SAMPLES);
  assign n_in    = room ? count + CW'(1) : count;
  assign sum_in  = room ? sum + 32'(sample) : sum;
  assign sum_mag = sum_in[31] ? 32'(-sum_in) : 32'(sum_in);

  always_ff @(posedge clk) begin
    if (acc_in && room) mem[count[AW-1:0]] <= sample;
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  logic [64:0] trial;
  logic [64:0] rsh;
  logic [63:0] q_step;
  always_comb begin
    rsh    = {r[63:0], num[63]};
    trial  = rsh - {32'd0, den};
    q_step = {q[62:0], !trial[64]};
  end

  // square root step terms
  logic [65:0] sq_rem;
  logic [65:0] sq_try;
  logic [31:0] root_step;
  always_comb begin
    sq_rem    = {r[63:0], num[63:62]};
    sq_try    = sq_rem - {q[63:0], 2'b01};
    root_step = {q[30:0], !sq_try[65]};
  end

  logic done_last;
  logic div_last;
  assign done_last = (idx == count);
  assign div_last  = (state == ST_VDIV) ? (iter == 7'd63) : (iter == 7'd39);

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (acc_in && is_last) begin
        if (n_in < CW'(2)) state_next = ST_OUT;
        else state_next = ST_MDIV;
      end
      ST_MDIV: if (iter == 7'd39) state_next = ST_MFIX;
      ST_MFIX: state_next = ST_RD;
      ST_RD:   state_next = ST_ACC;
      ST_ACC:  state_next = done_last ? ST_ADIV : ST_RD;
      ST_ADIV: if (iter == 7'd39) state_next = ST_VDIV;
      ST_VDIV: if (iter == 7'd63) state_next = ST_SQRT;
      ST_SQRT: if (iter == 7'd31) state_next = ST_OUT;
      ST_OUT:  if (!out_valid || out_ready) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  logic signed [31:0] dev;
  always_comb begin
    dev = 32'(signed'(rd_data)) * 32'sd256 - mean;
    ad  = dev[31] ? 33'(-dev) : {1'b0, dev};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; sum <= '0; ovf <= 1'b0; out_valid <= 1'b0; iter <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_LOAD: if (acc_in) begin
          if (is_last && n_in < CW'(2)) begin
            count <= '0; sum <= '0; ovf <= 1'b0;
            mean <= '0; mad_w <= '0; var_w <= '0; sd_w <= '0;
            stat_w <= STATUS_TOO_FEW;
          end else begin
            count <= n_in;
            sum   <= sum_in;
            ovf   <= ovf || !room;
            if (is_last) begin
              // mean numerator: |256*sum| as 40 bits at the top
              neg <= sum_in[31];
              num <= {sum_mag, 32'd0};
              den <= 33'(n_in);
              r <= '0; q <= '0; iter <= '0;
            end
          end
        end
        ST_MDIV, ST_ADIV, ST_VDIV: begin
          if (div_last && state == ST_ADIV) begin
            mad_w <= (|q_step[39:24]) ? 24'hFFFFFF : q_step[23:0];
            num <= sq_sum; den <= {7'd0, 26'(count - CW'(1))};
            r <= '0; q <= '0; iter <= '0;
          end else if (div_last && state == ST_VDIV) begin
            // q_step is the sum of squares over n-1; variance drops 8 bits
            var_w <= (|q_step[63:48]) ? 40'hFF_FFFF_FFFF : q_step[47:8];
            num <= q_step;
            r <= '0; q <= '0; iter <= '0;
          end else begin
            r <= trial[64] ? rsh[63:0] : trial[63:0];
            q <= q_step;
            num <= {num[62:0], 1'b0};
            iter <= div_last ? 7'd0 : iter + 7'd1;
          end
        end
        ST_MFIX: begin
          mean <= neg ? -signed'(q[31:0]) : signed'(q[31:0]);
          idx <= '0; abs_sum <= '0; sq_sum <= '0;
        end
        ST_RD: idx <= idx + CW'(1);
        ST_ACC: begin
          abs_sum <= abs_sum + 40'(ad);
          sq_sum  <= sq_sum + 64'(ad[31:0]) * 64'(ad[31:0]);
          if (done_last) begin
            num <= {abs_sum + 40'(ad), 24'd0};
            den <= 33'(count);
            r <= '0; q <= '0; iter <= '0;
          end
        end
        ST_SQRT: begin
          r <= sq_try[65] ? sq_rem[63:0] : sq_try[63:0];
          q <= {q[62:0], !sq_try[65]};
          num <= {num[61:0], 2'b00};
          iter <= iter + 7'd1;
          if (iter == 7'd31) begin
            sd_w <= (|root_step[31:24]) ? 24'hFFFFFF : root_step[23:0];
            stat_w <= ovf ? STATUS_OVERFLOW : STATUS_OK;
            count <= '0; sum <= '0; ovf <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register, loaded only when empty or being emptied
  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_value   <= mean[23:0];
      mean_abs_dev <= mad_w;
      variance     <= var_w;
      std_dev      <= sd_w;
      status       <= stat_w;
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> !in_ready) else $error("input accepted while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES)) else $error("count beyond depth");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> out_valid) else $error("result not raised");
`endif

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives sample sets into sample_mean_variance_moments and checks the mean,
// mean absolute deviation, variance, standard deviation and status of each
// set against an in-bench predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import smvm_pkg::*;

  localparam int unsigned DEPTH = MAX_SAMPLES_DEF;

  typedef struct packed {
    logic signed [23:0] mean_value;
    logic [23:0]        mean_abs_dev;
    logic [39:0]        variance;
    logic [23:0]        std_dev;
    status_t            status;
  } stats_t;

  class stats_scoreboard;
    logic signed [15:0] store[DEPTH];
    int unsigned        count;
    longint             total;
    bit                 dropped;
    stats_t             pending[$];
    int unsigned        errors;

    function void clear();
      count = 0;
      total = 0;
      dropped = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void note_sample(logic signed [15:0] s, logic last);
      stats_t          r;
      longint          n;
      longint          m;
      longint          d;
      longint unsigned abs_sum;
      longint unsigned sq_sum;
      longint unsigned per;
      if (count < DEPTH) begin
        store[count] = s;
        count++;
        total += s;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      r = '0;
      if (count < 2) begin
        r.status = STATUS_TOO_FEW;
      end else begin
        n = count;
        m = (total * 256) / n;
        abs_sum = 0;
        sq_sum = 0;
        for (int j = 0; j < count; j++) begin
          d = longint'(store[j]) * 256 - m;
          if (d < 0) d = -d;
          abs_sum += d;
          sq_sum += d * d;
        end
        per = sq_sum / (n - 1);
        r.mean_value = m[23:0];
        r.mean_abs_dev = (abs_sum / n > 64'hFFFFFF) ? 24'hFFFFFF : 24'(abs_sum / n);
        r.variance = (per / 256 > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : 40'(per / 256);
        r.std_dev = (int_sqrt(per) > 64'hFFFFFF) ? 24'hFFFFFF : 24'(int_sqrt(per));
        r.status = dropped ? STATUS_OVERFLOW : STATUS_OK;
      end
      pending.push_back(r);
      clear();
    endfunction

    function void check_result(stats_t got);
      stats_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected result %p", $realtime, got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] sample;
  logic               is_last;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] mean_value;
  logic [23:0]        mean_abs_dev;
  logic [39:0]        variance;
  logic [23:0]        std_dev;
  logic [1:0]         status;

  stats_scoreboard sb;
  bit              calm;
  bit              hold_off;
  bit              sending_done;
  int unsigned     items_sent;

  sample_mean_variance_moments DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

  // one transaction; the sender idles in front of it at random
  task automatic send_sample(logic signed [15:0] s, logic last);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sample <= s;
    is_last <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s, last);
    items_sent++;
  endtask

  task automatic send_set(int unsigned n, int unsigned kind);
    logic signed [15:0] s;
    int base;
    base = $urandom_range(65535) - 32768;
    for (int unsigned i = 0; i < n; i++) begin
      case (kind)
        0: s = 16'($urandom);
        1: s = (i % 2) ? 16'sh7FFF : 16'sh8000;
        2: s = 16'(base + int'($urandom_range(40)) - 20);
        default: s = $urandom_range(1) ? 16'sh7FFF : 16'sh7FFE;
      endcase
      send_sample(s, i == n - 1);
    end
  endtask

  task automatic pick_set();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) send_set($urandom_range(1), $urandom_range(3));
    else if (r < 8) send_set(DEPTH + $urandom_range(1, 6), $urandom_range(3));
    else if (r < 10) send_set(DEPTH - $urandom_range(1), $urandom_range(3));
    else send_set($urandom_range(2, 12), $urandom_range(3));
  endtask

  initial begin
    sb = new();
    sb.clear();
    calm = 0;
    hold_off = 0;
    sending_done = 0;
    items_sent = 0;
    rst <= 1;
    in_valid <= 0;
    sample <= 0;
    is_last <= 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: too few, extremes, flat data, full store, overflow
    send_set(1, 0);
    send_sample(16'sh7FFF, 0);
    send_sample(16'sh8000, 1);
    send_set(2, 1);
    send_set(3, 3);
    send_set(DEPTH, 1);
    send_set(DEPTH + 3, 1);
    send_sample(16'sh0000, 0);
    send_sample(16'shFFFF, 0);
    send_sample(16'sh5555, 0);
    send_sample(16'shAAAA, 1);
    // long stall on the receiver while sets keep arriving
    hold_off = 1;
    repeat (3) pick_set();
    hold_off = 0;
    while (items_sent < 1750) begin
      calm = (items_sent > 600 && items_sent < 900);
      pick_set();
    end
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    bit held;
    held = 0;
    out_ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      sb.check_result({mean_value, mean_abs_dev, variance, std_dev, status_t'(status)});

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
